// File: rtl/gqv_pkg.sv
package gqv_pkg;

  // Sampler table depth unless the top level is told otherwise
  localparam int DEFAULT_MAX_SAMPLERS = 32;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam int SLOT_W   = 5;
  localparam int SCALED_W = 40;

  // One glyph as it arrives
  typedef struct packed {
    logic signed [31:0] glyph_offset_x;
    logic signed [31:0] glyph_offset_y;
    logic [30:0]        glyph_width;
    logic [30:0]        glyph_height;
    logic signed [31:0] glyph_advance;
    logic [15:0]        tex_u_left;
    logic [15:0]        tex_v_top;
    logic [15:0]        tex_u_right;
    logic [15:0]        tex_v_bottom;
    logic [31:0]        texture_id;
    logic               first_of_string;
    logic               new_batch;
  } glyph_t;

  // One corner vertex as it leaves
  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        vertex_u;
    logic [15:0]        vertex_v;
    logic [SLOT_W-1:0]  sampler_slot;
    logic               last_vertex;
    logic               sampler_overflow;
  } vertex_t;

  // Classified glyph handed from front to back
  typedef struct packed {
    logic signed [SCALED_W-1:0] scaled_offset_x;
    logic signed [SCALED_W-1:0] scaled_offset_y;
    logic signed [SCALED_W-1:0] scaled_width;
    logic signed [SCALED_W-1:0] scaled_height;
    logic signed [SCALED_W-1:0] scaled_advance;
    logic [15:0]                tex_u_left;
    logic [15:0]                tex_v_top;
    logic [15:0]                tex_u_right;
    logic [15:0]                tex_v_bottom;
    logic [SLOT_W-1:0]          sampler_slot;
    logic                       sampler_overflow;
    logic                       first_of_string;
  } job_t;

  // Multiply a Q16.16 value by a Q8.16 reciprocal, round half up to Q24.16
  function automatic logic signed [SCALED_W-1:0] scale_q16(
    input logic signed [32:0] v,
    input logic [23:0]        r
  );
    logic signed [57:0] p;
    p = 58'(v) * 58'($signed({1'b0, r})) + 58'sd32768;
    return p[55:16];
  endfunction

  // Clamp a wide signed position to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd2147483647;
    lo = -44'sd2147483648;
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/glyph_quad_vertex_generator_unit.sv
// A glyph passes from the front's hold register through the queue, the position stage and
// the corner stage to the vertex output register, one vertex per cycle while not stalled.
// The front classifies one glyph per cycle into a 4-entry queue while it has room; the back drains it.
// Reset (rst, synchronous): empties the queue and stages, clears pen advance and sampler
// fill count, sets origins to 0 and reciprocals to 1.0; the sampler table is not cleared.
module glyph_quad_vertex_generator_unit #(
  parameter int MAX_SAMPLERS = gqv_pkg::DEFAULT_MAX_SAMPLERS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             glyph_valid,
  output logic             glyph_stall,
  input  gqv_pkg::glyph_t  glyph,
  output logic             vertex_valid,
  input  logic             vertex_stall,
  output gqv_pkg::vertex_t vertex,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import gqv_pkg::*;

  localparam logic [1:0] CFG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] CFG_INV_SCALE_X = 2'd2;
  localparam logic [1:0] CFG_INV_SCALE_Y = 2'd3;

  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [23:0]        inv_scale_x;
  logic [23:0]        inv_scale_y;

  logic push;
  logic full;
  logic pop;
  logic job_valid;
  job_t push_job;
  job_t pop_job;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      inv_scale_x <= 24'h010000;
      inv_scale_y <= 24'h010000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:    origin_x    <= cfg_data;
        CFG_ORIGIN_Y:    origin_y    <= cfg_data;
        CFG_INV_SCALE_X: inv_scale_x <= cfg_data[23:0];
        CFG_INV_SCALE_Y: inv_scale_y <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  gqv_front #(
    .MAX_SAMPLERS(MAX_SAMPLERS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .glyph_valid(glyph_valid),
    .glyph_stall(glyph_stall),
    .glyph      (glyph),
    .inv_scale_x(inv_scale_x),
    .inv_scale_y(inv_scale_y),
    .push       (push),
    .job        (push_job),
    .full       (full)
  );

  gqv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .pop     (pop),
    .pop_job (pop_job),
    .valid   (job_valid)
  );

  gqv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (pop_job),
    .pop         (pop),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .vertex_valid(vertex_valid),
    .vertex_stall(vertex_stall),
    .vertex      (vertex)
  );

endmodule

// File: rtl/gqv_front.sv
module gqv_front #(
  parameter int MAX_SAMPLERS = gqv_pkg::DEFAULT_MAX_SAMPLERS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            glyph_valid,
  output logic            glyph_stall,
  input  gqv_pkg::glyph_t glyph,
  input  logic [23:0]     inv_scale_x,
  input  logic [23:0]     inv_scale_y,
  output logic            push,
  output gqv_pkg::job_t   job,
  input  logic            full
);
  import gqv_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLERS + 1);
  localparam int IDX_W = (MAX_SAMPLERS > 1) ? $clog2(MAX_SAMPLERS) : 1;

  glyph_t            held;
  logic              held_valid;
  logic              accept;
  logic [31:0]       tex_table [MAX_SAMPLERS];
  logic [CNT_W-1:0]  slots_used;
  logic [CNT_W-1:0]  cnt_eff;
  logic [MAX_SAMPLERS-1:0] match;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] slot;
  logic              hit;
  logic              table_full;
  logic              insert;

  // Hold one glyph; pass it on as soon as the queue has room
  assign push        = held_valid & ~full;
  assign glyph_stall = held_valid & full;
  assign accept      = glyph_valid & ~glyph_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= accept | (held_valid & ~push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= glyph;
    end
  end

  // Compare the handle against every live table entry at once
  always_comb begin
    cnt_eff  = held.new_batch ? '0 : slots_used;
    match    = '0;
    hit_slot = '0;
    for (int i = 0; i < MAX_SAMPLERS; i++) begin
      if ((CNT_W'(i) < cnt_eff) && (tex_table[i] == held.texture_id)) begin
        match[i] = 1'b1;
        hit_slot = hit_slot | SLOT_W'(i);
      end
    end
    hit        = |match;
    table_full = (cnt_eff == CNT_W'(MAX_SAMPLERS));
    insert     = ~hit & ~table_full;
  end

  // Pick the slot: known handle, fresh entry, or slot 0 on overflow
  always_comb begin
    priority if (hit) begin
      slot = hit_slot;
    end else if (table_full) begin
      slot = '0;
    end else begin
      slot = SLOT_W'(cnt_eff);
    end
  end

  // Scale metrics and pack the job
  always_comb begin
    job.scaled_offset_x  = scale_q16(33'(held.glyph_offset_x), inv_scale_x);
    job.scaled_offset_y  = scale_q16(33'(held.glyph_offset_y), inv_scale_y);
    job.scaled_width     = scale_q16($signed({2'b00, held.glyph_width}), inv_scale_x);
    job.scaled_height    = scale_q16($signed({2'b00, held.glyph_height}), inv_scale_y);
    job.scaled_advance   = scale_q16(33'(held.glyph_advance), inv_scale_x);
    job.tex_u_left       = held.tex_u_left;
    job.tex_v_top        = held.tex_v_top;
    job.tex_u_right      = held.tex_u_right;
    job.tex_v_bottom     = held.tex_v_bottom;
    job.sampler_slot     = slot;
    job.sampler_overflow = ~hit & table_full;
    job.first_of_string  = held.first_of_string;
  end

  // Advance the fill count; a new batch restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else if (push) begin
      slots_used <= insert ? cnt_eff + CNT_W'(1) : cnt_eff;
    end
  end

  // Store a handle on first use
  always_ff @(posedge clk) begin
    if (push && insert) begin
      tex_table[cnt_eff[IDX_W-1:0]] <= held.texture_id;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(MAX_SAMPLERS))
    else $error("sampler fill count beyond table depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    push && job.sampler_overflow |=> slots_used == CNT_W'(MAX_SAMPLERS))
    else $error("sampler overflow flagged with table not full");

endmodule

// File: rtl/gqv_queue.sv
module gqv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gqv_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output gqv_pkg::job_t pop_job,
  output logic          valid
);
  import gqv_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign pop_job = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into full queue");

endmodule

// File: rtl/gqv_back.sv
module gqv_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  gqv_pkg::job_t      job,
  output logic               pop,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  output logic               vertex_valid,
  input  logic               vertex_stall,
  output gqv_pkg::vertex_t   vertex
);
  import gqv_pkg::*;

  typedef enum logic [3:0] {
    C_TL = 4'b0001,
    C_BL = 4'b0010,
    C_BR = 4'b0100,
    C_TR = 4'b1000
  } corner_t;

  // Position stage
  logic               s1_valid;
  logic signed [41:0] x0w;
  logic signed [40:0] y0w;
  logic signed [SCALED_W-1:0] sw;
  logic signed [SCALED_W-1:0] sh;
  logic [15:0]        s1_ul, s1_vt, s1_ur, s1_vb;
  logic [SLOT_W-1:0]  s1_slot;
  logic               s1_ovf;

  // Corner stage
  logic               s2_valid;
  logic signed [31:0] x0s, x1s, y0s, y1s;
  logic [15:0]        s2_ul, s2_vt, s2_ur, s2_vb;
  logic [SLOT_W-1:0]  s2_slot;
  logic               s2_ovf;
  corner_t            corner;

  logic signed [31:0] pen;
  logic signed [31:0] pen_eff;
  logic signed [41:0] x0_sum;
  logic signed [40:0] y0_sum;
  logic signed [40:0] pen_sum;
  logic signed [42:0] x1_sum;
  logic signed [41:0] y1_sum;
  vertex_t            vertex_next;
  logic               out_load;
  logic               s2_done;
  logic               s2_load;
  logic               s1_free;

  // Flow control: drain corners, then refill the stages behind
  assign out_load = s2_valid & (~vertex_valid | ~vertex_stall);
  assign s2_done  = out_load & (corner == C_TR);
  assign s2_load  = s1_valid & (~s2_valid | s2_done);
  assign s1_free  = ~s1_valid | s2_load;
  assign pop      = job_valid & s1_free;

  // Base corner, far corner sums and pen update
  always_comb begin
    pen_eff = job.first_of_string ? '0 : pen;
    x0_sum  = 42'(origin_x) + 42'(job.scaled_offset_x) + 42'(pen_eff);
    y0_sum  = 41'(origin_y) + 41'(job.scaled_offset_y);
    pen_sum = 41'(pen_eff) + 41'(job.scaled_advance);
    x1_sum  = 43'(x0w) + 43'(sw);
    y1_sum  = 42'(y0w) - 42'(sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (pop) begin
        pen <= sat32(44'(pen_sum));
      end
      s1_valid <= pop | (s1_valid & ~s2_load);
      s2_valid <= s2_load | (s2_valid & ~s2_done);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x0w     <= x0_sum;
      y0w     <= y0_sum;
      sw      <= job.scaled_width;
      sh      <= job.scaled_height;
      s1_ul   <= job.tex_u_left;
      s1_vt   <= job.tex_v_top;
      s1_ur   <= job.tex_u_right;
      s1_vb   <= job.tex_v_bottom;
      s1_slot <= job.sampler_slot;
      s1_ovf  <= job.sampler_overflow;
    end
  end

  // Far corner and saturation
  always_ff @(posedge clk) begin
    if (s2_load) begin
      x0s     <= sat32(44'(x0w));
      y0s     <= sat32(44'(y0w));
      x1s     <= sat32(44'(x1_sum));
      y1s     <= sat32(44'(y1_sum));
      s2_ul   <= s1_ul;
      s2_vt   <= s1_vt;
      s2_ur   <= s1_ur;
      s2_vb   <= s1_vb;
      s2_slot <= s1_slot;
      s2_ovf  <= s1_ovf;
    end
  end

  // Select the corner in turn
  always_comb begin
    vertex_next.sampler_slot     = s2_slot;
    vertex_next.sampler_overflow = s2_ovf;
    vertex_next.last_vertex      = 1'b0;
    unique case (corner)
      C_TL: begin
        vertex_next.vertex_x = x0s;
        vertex_next.vertex_y = y0s;
        vertex_next.vertex_u = s2_ul;
        vertex_next.vertex_v = s2_vt;
      end
      C_BL: begin
        vertex_next.vertex_x = x0s;
        vertex_next.vertex_y = y1s;
        vertex_next.vertex_u = s2_ul;
        vertex_next.vertex_v = s2_vb;
      end
      C_BR: begin
        vertex_next.vertex_x = x1s;
        vertex_next.vertex_y = y1s;
        vertex_next.vertex_u = s2_ur;
        vertex_next.vertex_v = s2_vb;
      end
      C_TR: begin
        vertex_next.vertex_x = x1s;
        vertex_next.vertex_y = y0s;
        vertex_next.vertex_u = s2_ur;
        vertex_next.vertex_v = s2_vt;
        vertex_next.last_vertex = 1'b1;
      end
      default: begin
        vertex_next.vertex_x = x0s;
        vertex_next.vertex_y = y0s;
        vertex_next.vertex_u = s2_ul;
        vertex_next.vertex_v = s2_vt;
      end
    endcase
  end

  // Step the corner on each loaded vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      corner       <= C_TL;
      vertex_valid <= 1'b0;
    end else begin
      if (out_load) begin
        unique case (corner)
          C_TL:    corner <= C_BL;
          C_BL:    corner <= C_BR;
          C_BR:    corner <= C_TR;
          C_TR:    corner <= C_TL;
          default: corner <= C_TL;
        endcase
      end
      if (out_load) begin
        vertex_valid <= 1'b1;
      end else if (!vertex_stall) begin
        vertex_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex <= vertex_next;
    end
  end

  a_corner_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(corner))
    else $error("corner sequencer lost its one-hot code");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    out_load && corner == C_TR |=> vertex_valid && vertex.last_vertex)
    else $error("fourth vertex not marked last");

  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid)
    else $error("popped job not held in position stage");

endmodule

// File: dv/glyph_quad_vertex_generator_unit_test.sv
`timescale 1ns / 100ps

module glyph_quad_vertex_generator_unit_test;
  import gqv_pkg::*;

  localparam int DIR_N = 16;
  localparam int MAX_SLOTS = DEFAULT_MAX_SAMPLERS;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 100;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_INV_SCALE_X = 2'd2;
  localparam logic [1:0] REG_INV_SCALE_Y = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        glyph_valid = 1'b0;
  logic        glyph_stall;
  glyph_t      glyph = '0;
  logic        vertex_valid;
  logic        vertex_stall = 1'b0;
  vertex_t     vertex;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_ORIGIN_X;
  logic [31:0] cfg_data = '0;

  glyph_quad_vertex_generator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .glyph_valid  (glyph_valid),
    .glyph_stall  (glyph_stall),
    .glyph        (glyph),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow of the block: configuration, sampler table, pen position
  longint      org_x = 0;
  longint      org_y = 0;
  logic [23:0] rcp_x = 24'h010000;
  logic [23:0] rcp_y = 24'h010000;
  logic [31:0] tex_table [MAX_SLOTS];
  int          slots_in_use = 0;
  longint      pen = 0;

  vertex_t pending_corners[$];
  vertex_t pred_quad [4];
  vertex_t want_corner;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;

  // Stimulus shaping
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  glyph_t  dir_glyph [DIR_N];
  bit      dir_typed [DIR_N];
  vertex_t typed_quad [DIR_N][4];

  logic [31:0] tex_pool [40];
  int          pool_n = 1;
  int          batch_left = 0;
  int          batch_pos = 0;
  bit          big_next = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round half up of v * r / 2^16; floor via arithmetic shift
  function automatic longint scale_q(input longint v, input logic [23:0] r);
    longint p;
    p = v * longint'({40'd0, r}) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic vertex_t corner(input longint x, input longint y,
                                     input logic [15:0] u, input logic [15:0] v,
                                     input int slot, input bit last, input bit ovf);
    vertex_t c;
    c.vertex_x         = 32'(clamp32(x));
    c.vertex_y         = 32'(clamp32(y));
    c.vertex_u         = u;
    c.vertex_v         = v;
    c.sampler_slot     = slot[SLOT_W-1:0];
    c.last_vertex      = last;
    c.sampler_overflow = ovf;
    return c;
  endfunction

  function automatic glyph_t pack_glyph(input logic [31:0] ox, input logic [31:0] oy,
                                        input logic [30:0] w, input logic [30:0] h,
                                        input logic [31:0] adv,
                                        input logic [15:0] ul, input logic [15:0] vt,
                                        input logic [15:0] ur, input logic [15:0] vb,
                                        input logic [31:0] tex, input bit first,
                                        input bit batch);
    glyph_t g;
    g.glyph_offset_x  = ox;
    g.glyph_offset_y  = oy;
    g.glyph_width     = w;
    g.glyph_height    = h;
    g.glyph_advance   = adv;
    g.tex_u_left      = ul;
    g.tex_v_top       = vt;
    g.tex_u_right     = ur;
    g.tex_v_bottom    = vb;
    g.texture_id      = tex;
    g.first_of_string = first;
    g.new_batch       = batch;
    return g;
  endfunction

  // Mostly small signed Q16.16 values, now and then the full range
  function automatic logic [31:0] rand_q16();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 3) == 0) return r;
    return {{11{r[20]}}, r[20:0]};
  endfunction

  function automatic logic [30:0] rand_size();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 3) == 0) return r[30:0];
    return {9'd0, r[21:0]};
  endfunction

  // Work out the four corners of one glyph and advance the shadow state
  task automatic build_quad(input glyph_t g);
    int     slot;
    bit     hit;
    bit     ovf;
    longint x0, y0, x1, y1;
    slot = 0;
    hit  = 1'b0;
    ovf  = 1'b0;
    if (g.new_batch) slots_in_use = 0;
    if (g.first_of_string) pen = 0;
    for (int i = 0; i < slots_in_use; i++) begin
      if (!hit && tex_table[i] == g.texture_id) begin
        slot = i;
        hit  = 1'b1;
      end
    end
    if (!hit) begin
      if (slots_in_use < MAX_SLOTS) begin
        tex_table[slots_in_use] = g.texture_id;
        slot = slots_in_use;
        slots_in_use++;
      end else begin
        ovf = 1'b1;
      end
    end
    x0 = org_x + scale_q(longint'($signed(g.glyph_offset_x)), rcp_x) + pen;
    y0 = org_y + scale_q(longint'($signed(g.glyph_offset_y)), rcp_y);
    x1 = x0 + scale_q(longint'({1'b0, g.glyph_width}), rcp_x);
    y1 = y0 - scale_q(longint'({1'b0, g.glyph_height}), rcp_y);
    pred_quad[0] = corner(x0, y0, g.tex_u_left, g.tex_v_top, slot, 1'b0, ovf);
    pred_quad[1] = corner(x0, y1, g.tex_u_left, g.tex_v_bottom, slot, 1'b0, ovf);
    pred_quad[2] = corner(x1, y1, g.tex_u_right, g.tex_v_bottom, slot, 1'b0, ovf);
    pred_quad[3] = corner(x1, y0, g.tex_u_right, g.tex_v_top, slot, 1'b1, ovf);
    pen = clamp32(pen + scale_q(longint'($signed(g.glyph_advance)), rcp_x));
  endtask

  // Offer one glyph after an optional gap; hold it until the transfer
  task automatic send_glyph(input glyph_t g, input int typed_row);
    vertex_t exp_corner;
    while ($urandom_range(0, 99) < gap_pct) begin
      glyph_valid <= 1'b0;
      @(negedge clk);
    end
    glyph       <= g;
    glyph_valid <= 1'b1;
    @(posedge clk);
    while (glyph_stall) @(posedge clk);
    build_quad(g);
    for (int k = 0; k < 4; k++) begin
      exp_corner = (typed_row >= 0) ? typed_quad[typed_row][k] : pred_quad[k];
      pending_corners = {pending_corners, exp_corner};
    end
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding vertex
  task automatic wait_drained();
    glyph_valid <= 1'b0;
    @(negedge clk);
    while (pending_corners.size() != 0) @(negedge clk);
  endtask

  task automatic apply_config(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [23:0] sx, input logic [23:0] sy);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= ox;
    @(negedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= oy;
    @(negedge clk);
    cfg_index <= REG_INV_SCALE_X;
    cfg_data  <= {8'($urandom), sx};
    @(negedge clk);
    cfg_index <= REG_INV_SCALE_Y;
    cfg_data  <= {8'($urandom), sy};
    @(negedge clk);
    cfg_write <= 1'b0;
    org_x = longint'($signed(ox));
    org_y = longint'($signed(oy));
    rcp_x = sx;
    rcp_y = sy;
  endtask

  // Batches of glyphs sharing a small texture pool; some pools overfill the table
  task automatic next_random_glyph(output glyph_t g);
    int pick;
    g = '0;
    if (batch_left == 0) begin
      if (big_next || $urandom_range(0, 3) == 0) begin
        pool_n     = 40;
        batch_left = 50;
      end else begin
        pool_n     = $urandom_range(1, 8);
        batch_left = $urandom_range(2, 16);
      end
      big_next = 1'b0;
      for (int i = 0; i < pool_n; i++) tex_pool[i] = $urandom;
      batch_pos         = 0;
      g.new_batch       = 1'b1;
      g.first_of_string = 1'b1;
    end else begin
      g.new_batch       = ($urandom_range(0, 40) == 0);
      g.first_of_string = ($urandom_range(0, 5) == 0);
    end
    pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, pool_n - 1) : batch_pos % pool_n;
    g.texture_id     = ($urandom_range(0, 31) == 0) ? $urandom : tex_pool[pick];
    g.glyph_offset_x = rand_q16();
    g.glyph_offset_y = rand_q16();
    g.glyph_width    = rand_size();
    g.glyph_height   = rand_size();
    g.glyph_advance  = rand_q16();
    g.tex_u_left     = 16'($urandom);
    g.tex_v_top      = 16'($urandom);
    g.tex_u_right    = 16'($urandom);
    g.tex_v_bottom   = 16'($urandom);
    batch_pos++;
    batch_left--;
  endtask

  task automatic run_phase(input int n, input int gap, input int stall, input bit hold);
    glyph_t g;
    @(posedge clk);
    stall_pct = stall;
    hold_req  = hold;
    @(negedge clk);
    gap_pct = gap;
    for (int i = 0; i < n; i++) begin
      next_random_glyph(g);
      send_glyph(g, -1);
    end
  endtask

  // Receiver stall, with a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        vertex_stall <= 1'b1;
      end else begin
        vertex_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    mismatch_count++;
  endtask

  // Check each vertex transfer against the oldest pending corner
  always @(posedge clk) begin
    if (!rst && vertex_valid && !vertex_stall) begin
      if (pending_corners.size() == 0) begin
        $display("%0t: vertex expected none, actual %h", $time, vertex);
        mismatch_count++;
      end else begin
        want_corner = pending_corners.pop_front();
        if (vertex.vertex_x !== want_corner.vertex_x)
          report_field("vertex_x", want_corner.vertex_x, vertex.vertex_x);
        if (vertex.vertex_y !== want_corner.vertex_y)
          report_field("vertex_y", want_corner.vertex_y, vertex.vertex_y);
        if (vertex.vertex_u !== want_corner.vertex_u)
          report_field("vertex_u", 32'(want_corner.vertex_u), 32'(vertex.vertex_u));
        if (vertex.vertex_v !== want_corner.vertex_v)
          report_field("vertex_v", 32'(want_corner.vertex_v), 32'(vertex.vertex_v));
        if (vertex.sampler_slot !== want_corner.sampler_slot)
          report_field("sampler_slot", 32'(want_corner.sampler_slot),
                       32'(vertex.sampler_slot));
        if (vertex.last_vertex !== want_corner.last_vertex)
          report_field("last_vertex", 32'(want_corner.last_vertex),
                       32'(vertex.last_vertex));
        if (vertex.sampler_overflow !== want_corner.sampler_overflow)
          report_field("sampler_overflow", 32'(want_corner.sampler_overflow),
                       32'(vertex.sampler_overflow));
      end
    end
  end

  // Abort when neither channel has moved a transfer for too long
  always @(posedge clk) begin
    if ((glyph_valid && !glyph_stall) || (vertex_valid && !vertex_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // Directed glyphs under reset configuration
    dir_glyph[0]  = pack_glyph(32'h0, 32'h0, 31'h10000, 31'h10000, 32'h20000,
                               16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 32'hAAAA5555,
                               1'b1, 1'b1);
    dir_glyph[1]  = pack_glyph(32'h0, 32'h0, 31'h0, 31'h0, 32'h8000,
                               16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 32'hAAAA5555,
                               1'b0, 1'b0);
    dir_glyph[2]  = pack_glyph(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF,
                               32'h7FFFFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                               32'hFFFFFFFF, 1'b1, 1'b0);
    // pen saturates high, then low
    dir_glyph[3]  = pack_glyph(32'h0, 32'h0, 31'h5, 31'h3, 32'h7FFFFFFF,
                               16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 32'h0, 1'b0, 1'b0);
    dir_glyph[4]  = pack_glyph(32'hFFFFFFFF, 32'h1, 31'h1, 31'h1, 32'h80000000,
                               16'h0002, 16'h0004, 16'h0008, 16'h0010, 32'hAAAA5555,
                               1'b0, 1'b0);
    dir_glyph[5]  = pack_glyph(32'h80000000, 32'h7FFFFFFF, 31'h0, 31'h7FFFFFFF, 32'h80000000,
                               16'h0100, 16'h0200, 16'h0400, 16'h0800, 32'h12345678,
                               1'b1, 1'b0);
    dir_glyph[6]  = pack_glyph(32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h0, 32'h80000000,
                               16'h1000, 16'h2000, 16'h4000, 16'h8000, 32'hFFFFFFFF,
                               1'b0, 1'b0);
    // fresh batch: slots handed out again from zero
    dir_glyph[7]  = pack_glyph(32'h10000, 32'hFFFF0000, 31'h28000, 31'h18000, 32'h18000,
                               16'h0010, 16'h0020, 16'h0030, 16'h0040, 32'hFFFFFFFF,
                               1'b1, 1'b1);
    dir_glyph[8]  = pack_glyph(32'h8000, 32'h4000, 31'h10000, 31'h20000, 32'h18000,
                               16'h0050, 16'h0060, 16'h0070, 16'h0080, 32'hAAAA5555,
                               1'b0, 1'b0);
    dir_glyph[9]  = pack_glyph(32'hFFFF8000, 32'h0, 31'h30000, 31'h10000, 32'h10000,
                               16'h0090, 16'h00A0, 16'h00B0, 16'h00C0, 32'h0, 1'b0, 1'b0);
    dir_glyph[10] = pack_glyph(32'h0, 32'h0, 31'h10000, 31'h10000, 32'hFFFF0000,
                               16'h00D0, 16'h00E0, 16'h00F0, 16'h0100, 32'hFFFFFFFF,
                               1'b0, 1'b0);
    dir_glyph[11] = pack_glyph(32'h0, 32'h0, 31'h10000, 31'h10000, 32'h10000,
                               16'h0110, 16'h0120, 16'h0130, 16'h0140, 32'h0, 1'b0, 1'b1);
    // alternating bit patterns
    dir_glyph[12] = pack_glyph(32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 31'h55555555,
                               32'h55555555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                               32'h55555555, 1'b0, 1'b0);
    dir_glyph[13] = pack_glyph(32'hAAAAAAAA, 32'h55555555, 31'h55555555, 31'h2AAAAAAA,
                               32'hAAAAAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                               32'hAAAAAAAA, 1'b1, 1'b0);
    dir_glyph[14] = pack_glyph(32'h0, 32'h0, 31'h0, 31'h0, 32'h0,
                               16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, 1'b0);
    dir_glyph[15] = pack_glyph(32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                               32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               32'hFFFFFFFF, 1'b1, 1'b1);
    for (int i = 0; i < DIR_N; i++) dir_typed[i] = (i < 3);

    // Unit quad at the origin after reset
    typed_quad[0][0] = corner(0, 0, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
    typed_quad[0][1] = corner(0, -65536, 16'h0000, 16'hFFFF, 0, 1'b0, 1'b0);
    typed_quad[0][2] = corner(65536, -65536, 16'hFFFF, 16'hFFFF, 0, 1'b0, 1'b0);
    typed_quad[0][3] = corner(65536, 0, 16'hFFFF, 16'h0000, 0, 1'b1, 1'b0);
    // Empty quad sitting at the pen position of two units
    typed_quad[1][0] = corner(131072, 0, 16'h1234, 16'h5678, 0, 1'b0, 1'b0);
    typed_quad[1][1] = corner(131072, 0, 16'h1234, 16'hDEF0, 0, 1'b0, 1'b0);
    typed_quad[1][2] = corner(131072, 0, 16'h9ABC, 16'hDEF0, 0, 1'b0, 1'b0);
    typed_quad[1][3] = corner(131072, 0, 16'h9ABC, 16'h5678, 0, 1'b1, 1'b0);
    // Every corner pinned to the rails, second texture of the batch
    typed_quad[2][0] = corner(Q_MAX, Q_MIN, 16'hFFFF, 16'h0000, 1, 1'b0, 1'b0);
    typed_quad[2][1] = corner(Q_MAX, Q_MIN, 16'hFFFF, 16'hFFFF, 1, 1'b0, 1'b0);
    typed_quad[2][2] = corner(Q_MAX, Q_MIN, 16'h0000, 16'hFFFF, 1, 1'b0, 1'b0);
    typed_quad[2][3] = corner(Q_MAX, Q_MIN, 16'h0000, 16'h0000, 1, 1'b1, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) send_glyph(dir_glyph[i], dir_typed[i] ? i : -1);

    apply_config($urandom, $urandom, 24'($urandom), 24'($urandom));
    run_phase(80, 0, 0, 1'b0);
    apply_config(32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 24'h000000);
    run_phase(80, 47, 0, 1'b0);
    apply_config(32'h80000000, 32'h7FFFFFFF, 24'h000000, 24'hFFFFFF);
    run_phase(80, 0, 47, 1'b0);
    apply_config(rand_q16(), rand_q16(), 24'($urandom_range(16384, 262144)),
                 24'($urandom_range(16384, 262144)));
    run_phase(80, 19, 19, 1'b1 == 1'b0);
    // Back-pressure: long receiver hold-off, then a full drain mid-stream
    apply_config(32'h0, 32'h0, 24'h010000, 24'h010000);
    run_phase(40, 0, 0, 1'b1);
    wait_drained();
    run_phase(40, 0, 0, 1'b0);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_corners.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
